// ----- rtl/cbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbpm_pkg
// Shared types and constants of the clock buffer pool manager.
// ----------------------------------------------------------------------------
`default_nettype none
package cbpm_pkg;
   localparam int FRAMES_DEF   = 16;
   localparam int PIN_BITS_DEF = 8;
   localparam int FILE_W       = 8;
   localparam int PAGE_W       = 20;

   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_UNPIN   = 2'd1,
      KIND_ALLOC   = 2'd2,
      KIND_DISPOSE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ALL_PINNED = 2'd1,
      ST_NOT_FOUND  = 2'd2,
      ST_NOT_PINNED = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture request, start the lookup scan
      logic scan;     // look at one frame of the lookup scan
      logic apply;    // act on the lookup result
      logic sweep;    // look at the frame under the hand
      logic fail;     // sweep ran out of tries
      logic show;     // result is final, move it to the output
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic found;
      logic is_fill;  // read or allocate request
      logic taken;    // current sweep step takes the frame
      logic tries_out;
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/clock_buffer_pool_manager.sv -----
// ----------------------------------------------------------------------------
// clock_buffer_pool_manager
// Frame table of a page buffer pool with clock (second-chance) replacement.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit first)
//  req_    | in        | file_id[7:0], page_number[27:8], mark_dirty[28]; tuser kind
//  rsp_    | out       | status, frame_index, hit, writeback_needed/file/page
//
//  The lookup scans one tag per cycle through one read port; a hit or a
//  non-fill request is then acted on. On a fill miss the clock sweep takes
//  a free or an unreferenced, unpinned frame, or fails when all are pinned.
//  The next word can be taken once the result is valid.
//  Reset clears all marks and pin counts at once; no clearing pass.
//  A stalled result is held in the output register while the next word is
//  processed; that word's result then waits until the output drains.
`default_nettype none
module clock_buffer_pool_manager #(
   parameter int FRAMES   = cbpm_pkg::FRAMES_DEF,
   parameter int PIN_BITS = cbpm_pkg::PIN_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // file_id[7:0], page_number[27:8], mark_dirty[28]
   input  wire  [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], frame_index[5:2], hit[6],
                                    // writeback_needed[7], writeback_file[15:8],
                                    // writeback_page[35:16]
);
   import cbpm_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [1:0]        st;
   logic [3:0]        fr;
   logic              hit, wb;
   logic [FILE_W-1:0] wbf;
   logic [PAGE_W-1:0] wbp;

   cbpm_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .rsp_tvalid, .rsp_tready, .sts, .cmd
   );

   cbpm_datapath #(.FRAMES(FRAMES), .PIN_BITS(PIN_BITS)) u_dp (
      .clock, .reset,
      .in_kind(req_tuser), .in_file(req_tdata[7:0]),
      .in_page(req_tdata[27:8]), .in_dirty(req_tdata[28]),
      .cmd, .sts,
      .out_status(st), .out_frame(fr), .out_hit(hit), .out_wb(wb),
      .out_wb_file(wbf), .out_wb_page(wbp)
   );

   assign rsp_tdata = {4'b0, wbp, wbf, wb, hit, fr, st};
endmodule
`default_nettype wire

// ----- rtl/cbpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbpm_ctrl
// Controller: sequences lookup scan, request action, clock sweep and output.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpm_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  cbpm_pkg::sts_type   sts,
   output cbpm_pkg::cmd_type   cmd
);
   import cbpm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_APPLY = 5'b00100,
      S_SWEEP = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   // A new word is taken whenever the controller is idle. If the previous
   // result is still stalled, the new result waits in S_OUT.
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            if (sts.is_fill && !sts.found) begin
               state_in = S_SWEEP;
            end else begin
               cmd.apply = 1'b1;
               state_in  = S_OUT;
            end
         end
         S_SWEEP: begin
            if (sts.tries_out) begin
               cmd.fail = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.sweep = 1'b1;
               if (sts.taken) state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.show     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/cbpm_datapath.sv -----
// ----------------------------------------------------------------------------
// cbpm_datapath
// Frame table, lookup scan, clock hand and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpm_datapath #(
   parameter int FRAMES   = cbpm_pkg::FRAMES_DEF,
   parameter int PIN_BITS = cbpm_pkg::PIN_BITS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire [1:0]                  in_kind,
   input  wire [cbpm_pkg::FILE_W-1:0] in_file,
   input  wire [cbpm_pkg::PAGE_W-1:0] in_page,
   input  wire                        in_dirty,
   input  cbpm_pkg::cmd_type          cmd,
   output cbpm_pkg::sts_type          sts,
   output logic [1:0]                 out_status,
   output logic [3:0]                 out_frame,
   output logic                       out_hit,
   output logic                       out_wb,
   output logic [cbpm_pkg::FILE_W-1:0] out_wb_file,
   output logic [cbpm_pkg::PAGE_W-1:0] out_wb_page
);
   import cbpm_pkg::*;

   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int TW = $clog2(2 * FRAMES + 1);
   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
   localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);

   logic [FRAMES-1:0]   valid_ff, ref_ff, dirty_ff;
   logic [PIN_BITS-1:0] pin_ff [FRAMES];
   logic [FILE_W-1:0]   tfile_mem [FRAMES];
   logic [PAGE_W-1:0]   tpage_mem [FRAMES];
   logic [IW-1:0]       hand_ff, hand_in;

   logic [1:0]          kind_ff;
   logic [FILE_W-1:0]   file_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic                mdirty_ff;

   // Lookup scan reads one tag per cycle through a registered read port.
   logic [IW:0]         scan_ff;
   logic [IW-1:0]       rd_idx_ff, hit_idx_ff;
   logic                rd_live_ff, found_ff;
   logic [FILE_W-1:0]   rd_file_ff;
   logic [PAGE_W-1:0]   rd_page_ff;
   logic [TW-1:0]       tries_ff;

   logic [1:0]          r_status_ff;
   logic [IW-1:0]       r_frame_ff;
   logic                r_hit_ff, r_wb_ff;
   logic [FILE_W-1:0]   r_wbf_ff;
   logic [PAGE_W-1:0]   r_wbp_ff;

   // Victim tag read port: registered, addressed by the next hand position,
   // so it holds the tag under the hand in every cycle.
   logic [FILE_W-1:0]   vfile_ff;
   logic [PAGE_W-1:0]   vpage_ff;
   logic                hv, hr, hp0, rd_match;

   always_comb begin
      if (reset)
         hand_in = LAST;
      else if (cmd.sweep)
         hand_in = (hand_ff == LAST) ? '0 : hand_ff + 1'b1;
      else
         hand_in = hand_ff;
   end

   assign hv       = valid_ff[hand_ff];
   assign hr       = ref_ff[hand_ff];
   assign hp0      = (pin_ff[hand_ff] == '0);
   assign rd_match = rd_live_ff && valid_ff[rd_idx_ff] &&
                     rd_file_ff == file_ff && rd_page_ff == page_ff;

   assign sts.scan_done = (scan_ff == (IW+1)'(FRAMES)) && !rd_live_ff;
   assign sts.found     = found_ff;
   assign sts.is_fill   = (kind_ff == KIND_READ) || (kind_ff == KIND_ALLOC);
   assign sts.taken     = !hv || (!hr && hp0);
   assign sts.tries_out = (tries_ff == TW'(2 * FRAMES));

   always_ff @(posedge clock) begin
      vfile_ff <= tfile_mem[hand_in];
      vpage_ff <= tpage_mem[hand_in];
      if (cmd.load) begin
         kind_ff   <= in_kind;
         file_ff   <= in_file;
         page_ff   <= in_page;
         mdirty_ff <= in_dirty;
      end
      if (cmd.load) begin
         scan_ff    <= '0;
         rd_live_ff <= 1'b0;
         found_ff   <= 1'b0;
         tries_ff   <= '0;
         r_status_ff <= ST_OK;
         r_frame_ff <= '0;
         r_hit_ff   <= 1'b0;
         r_wb_ff    <= 1'b0;
         r_wbf_ff   <= '0;
         r_wbp_ff   <= '0;
      end else if (cmd.scan) begin
         if (rd_match && !found_ff) begin
            found_ff   <= 1'b1;
            hit_idx_ff <= rd_idx_ff;
         end
         if (scan_ff != (IW+1)'(FRAMES)) begin
            rd_file_ff <= tfile_mem[scan_ff[IW-1:0]];
            rd_page_ff <= tpage_mem[scan_ff[IW-1:0]];
            rd_idx_ff  <= scan_ff[IW-1:0];
            rd_live_ff <= 1'b1;
            scan_ff    <= scan_ff + 1'b1;
         end else begin
            rd_live_ff <= 1'b0;
         end
      end
      if (cmd.sweep) begin
         tries_ff <= tries_ff + 1'b1;
         if (sts.taken) begin
            r_frame_ff <= hand_ff;
            if (hv && dirty_ff[hand_ff]) begin
               r_wb_ff  <= 1'b1;
               r_wbf_ff <= vfile_ff;
               r_wbp_ff <= vpage_ff;
            end
            tfile_mem[hand_ff] <= file_ff;
            tpage_mem[hand_ff] <= page_ff;
         end
      end
      if (cmd.fail) r_status_ff <= ST_ALL_PINNED;
      if (cmd.apply && found_ff) begin
         r_frame_ff <= hit_idx_ff;
         r_hit_ff   <= 1'b1;
         if (kind_ff == KIND_UNPIN && pin_ff[hit_idx_ff] == '0)
            r_status_ff <= ST_NOT_PINNED;
      end
      if (cmd.apply && !found_ff && kind_ff == KIND_UNPIN)
         r_status_ff <= ST_NOT_FOUND;
      if (cmd.show) begin
         out_status  <= r_status_ff;
         out_frame   <= 4'(r_frame_ff);
         out_hit     <= r_hit_ff;
         out_wb      <= r_wb_ff;
         out_wb_file <= r_wbf_ff;
         out_wb_page <= r_wbp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ref_ff   <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < FRAMES; i++) pin_ff[i] <= '0;
         hand_ff  <= LAST;
      end else begin
         hand_ff <= hand_in;
         if (cmd.sweep) begin
            if (sts.taken) begin
               valid_ff[hand_ff] <= 1'b1;
               ref_ff[hand_ff]   <= 1'b1;
               dirty_ff[hand_ff] <= 1'b0;
               pin_ff[hand_ff]   <= PIN_BITS'(1);
            end else if (hr) begin
               ref_ff[hand_ff] <= 1'b0;
            end
         end
         if (cmd.apply && found_ff) begin
            case (kind_ff) inside
               KIND_READ, KIND_ALLOC: begin
                  ref_ff[hit_idx_ff] <= 1'b1;
                  if (pin_ff[hit_idx_ff] != PIN_MAX)
                     pin_ff[hit_idx_ff] <= pin_ff[hit_idx_ff] + 1'b1;
               end
               KIND_UNPIN: begin
                  if (pin_ff[hit_idx_ff] != '0) begin
                     pin_ff[hit_idx_ff] <= pin_ff[hit_idx_ff] - 1'b1;
                     if (mdirty_ff) dirty_ff[hit_idx_ff] <= 1'b1;
                  end
               end
               default: begin
                  valid_ff[hit_idx_ff] <= 1'b0;
                  ref_ff[hit_idx_ff]   <= 1'b0;
                  dirty_ff[hit_idx_ff] <= 1'b0;
                  pin_ff[hit_idx_ff]   <= '0;
               end
            endcase
         end
      end
   end
endmodule
`default_nettype wire

// ----- rtl/cbpm_checker.sv -----
// ----------------------------------------------------------------------------
// cbpm_checker
// Port-level checks of the clock buffer pool manager.
// ----------------------------------------------------------------------------
`default_nettype none
module cbpm_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata
);
   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // An accepted word keeps the input busy: no new word is taken right behind it.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // Write-back data is zero unless a write-back is flagged.
   a_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[7] |-> rsp_tdata[35:8] == 28'd0)
      else $error("stray write-back tag");

   // Unused padding stays zero.
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:36] == 4'd0)
      else $error("padding set");
endmodule

bind clock_buffer_pool_manager cbpm_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready,
   .rsp_tvalid, .rsp_tready, .rsp_tdata
);
`default_nettype wire
